// File: src/ffha_pkg.sv
// Shared constants and types for the first-fit heap allocator.
package ffha_pkg;

	localparam int HEAP_BYTES   = 65536;
	localparam int HEADER_BYTES = 12;
	localparam int ADDR_W       = 16;
	localparam int OUTCOME_W    = 2;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_ALLOC = 2'd0,
		OUT_OOM   = 2'd1,
		OUT_FREED = 2'd2
	} outcome_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_A_RD,
		ST_A_CHK,
		ST_A_SPL,
		ST_A_NN,
		ST_A_NB,
		ST_F_WCHK,
		ST_F_T,
		ST_F_N,
		ST_F_P,
		ST_F_AF,
		ST_DONE
	} state_t;

endpackage

// File: src/ffha_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// File: src/first_fit_heap_allocator.sv
// First-fit heap allocator: top level with the tag memory sequencer.
//
// The block manages a heap as a chain of blocks, each with a tag (size in
// words, index of the previous block, free flag) held in one tag memory.
// Requests come in on the input channel (in_valid, in_stall): opcode selects
// allocate or free, request_bytes and block_address carry the operands.
// Each request gives exactly one result on the output channel (out_valid,
// out_stall): user_address and outcome.
// An allocate reads block tags one after another from the rover until a
// fitting free block or the heap end, then splits the chosen block. A free
// walks the chain from the heap start to check the address (one tag for
// each block before the freed one), then reads the tags of the freed block
// and its neighbours and merges; a rejected address skips the merge.
// The walks are paced by the single read port of the tag memory, which
// delivers one tag a cycle. One request is in work at a time; in_stall is
// high while a request is in work or its result has not been handed on.
// After reset the block writes the initial free block into tag entry 0
// before it takes a request. A result that the receiver stalls stays in
// the output register; the next request may be taken meanwhile, and its
// result waits until the register is free.
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  logic [ffha_pkg::ADDR_W-1:0]    request_bytes,
	input  logic [ffha_pkg::ADDR_W-1:0]    block_address,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ffha_pkg::ADDR_W-1:0]    user_address,
	output logic [ffha_pkg::OUTCOME_W-1:0] outcome
);

	localparam int AW         = ffha_pkg::ADDR_W;
	localparam int HEAP_WORDS = HEAP_BYTES / 4;
	localparam int IDX_W      = $clog2(HEAP_WORDS);
	localparam int SIZE_W     = IDX_W + 1;
	localparam int TAG_W      = SIZE_W + IDX_W + 1;
	localparam int SUM_W      = AW + 1;
	localparam int NEED_W     = SUM_W - 2;
	localparam int CMP_W      = (SIZE_W > NEED_W) ? SIZE_W : NEED_W;
	localparam int LW         = (SIZE_W > AW) ? SIZE_W : AW;
	localparam int BA_W       = (IDX_W + 2 > AW) ? IDX_W + 2 : AW;
	localparam int REM_MAX    = HEADER_BYTES / 4;

	ffha_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0]  rover_q, rover_d;
	logic              out_valid_q, out_valid_d;
	logic [AW-1:0]     out_addr_q, out_addr_d;
	logic [ffha_pkg::OUTCOME_W-1:0] out_code_q, out_code_d;

	logic [SIZE_W-1:0] cur_q, cur_d;
	logic [NEED_W-1:0] need_q, need_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [TAG_W-1:0]  t_q, t_d;
	logic [SIZE_W-1:0] nx_q, nx_d;
	logic              nfree_q, nfree_d;
	logic [SIZE_W-1:0] nsize_q, nsize_d;
	logic [IDX_W-1:0]  head_q, head_d;
	logic [IDX_W-1:0]  after_q, after_d;
	logic [IDX_W-1:0]  nb_q, nb_d;
	logic [SIZE_W-1:0] rem_q, rem_d;
	logic [IDX_W-1:0]  nn_q, nn_d;
	logic [AW-1:0]     res_addr_q, res_addr_d;
	logic [ffha_pkg::OUTCOME_W-1:0] res_code_q, res_code_d;

	// Tag memory ports.
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [TAG_W-1:0]  wr_data;
	logic [IDX_W-1:0]  rd_addr;
	logic [TAG_W-1:0]  rd_data;

	logic [SIZE_W-1:0] rd_size, t_size;
	logic [IDX_W-1:0]  rd_prev, t_prev;
	logic              rd_free;

	// Combinational working values.
	logic [SUM_W-1:0]  req_sum;
	logic [AW-1:0]     free_base;
	logic [LW-1:0]     free_idx_ext;
	logic              free_ok;
	logic [SIZE_W-1:0] step_pos;
	logic [SIZE_W-1:0] rem_w;
	logic [SIZE_W-1:0] end_w;
	logic [SIZE_W-1:0] nb_w;
	logic [SIZE_W-1:0] size_i;
	logic [SIZE_W-1:0] hsize;
	logic [IDX_W-1:0]  head_w;
	logic [SIZE_W-1:0] after_w;
	logic [BA_W-1:0]   byte_addr;
	logic              out_free;

	assign rd_size = rd_data[TAG_W-1 -: SIZE_W];
	assign rd_prev = rd_data[IDX_W:1];
	assign rd_free = rd_data[0];
	assign t_size  = t_q[TAG_W-1 -: SIZE_W];
	assign t_prev  = t_q[IDX_W:1];

	assign in_stall     = (state_q != ffha_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign user_address = out_addr_q;
	assign outcome      = out_code_q;
	assign out_free     = !out_valid_q || !out_stall;

	// Request decoding: rounded word count and freed block index.
	assign req_sum      = {1'b0, request_bytes} + SUM_W'(HEADER_BYTES + 3);
	assign free_base    = block_address - AW'(HEADER_BYTES);
	assign free_idx_ext = LW'(free_base[AW-1:2]);
	assign free_ok      = (block_address >= AW'(HEADER_BYTES)) && (free_base[1:0] == 2'b00)
		&& (free_idx_ext < LW'(HEAP_WORDS));
	assign byte_addr    = BA_W'({cur_q[IDX_W-1:0], 2'b00}) + BA_W'(HEADER_BYTES);

	ffha_ram #(
		.WIDTH (TAG_W),
		.DEPTH (HEAP_WORDS)
	) u_tags (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Next state, memory accesses and register updates.
	always_comb begin
		state_d     = state_q;
		rover_d     = rover_q;
		out_valid_d = out_valid_q && out_stall;
		out_addr_d  = out_addr_q;
		out_code_d  = out_code_q;
		cur_d       = cur_q;
		need_d      = need_q;
		idx_d       = idx_q;
		t_d         = t_q;
		nx_d        = nx_q;
		nfree_d     = nfree_q;
		nsize_d     = nsize_q;
		head_d      = head_q;
		after_d     = after_q;
		nb_d        = nb_q;
		rem_d       = rem_q;
		nn_d        = nn_q;
		res_addr_d  = res_addr_q;
		res_code_d  = res_code_q;
		wr_en       = 1'b0;
		wr_addr     = '0;
		wr_data     = '0;
		rd_addr     = '0;
		step_pos    = '0;
		rem_w       = t_size - SIZE_W'(need_q);
		end_w       = cur_q + t_size;
		nb_w        = cur_q + SIZE_W'(need_q);
		size_i      = t_size + (nfree_q ? nsize_q : '0);
		hsize       = size_i;
		head_w      = idx_q;
		after_w     = '0;

		case (state_q)
			ffha_pkg::ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = {SIZE_W'(HEAP_WORDS), IDX_W'(0), 1'b1};
				state_d = ffha_pkg::ST_IDLE;
			end
			ffha_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (opcode == ffha_pkg::OP_ALLOC) begin
						need_d  = req_sum[SUM_W-1:2];
						cur_d   = SIZE_W'(rover_q);
						state_d = ffha_pkg::ST_A_RD;
					end else begin
						res_addr_d = '0;
						res_code_d = ffha_pkg::OUT_FREED;
						idx_d      = free_idx_ext[IDX_W-1:0];
						cur_d      = '0;
						if (!free_ok) begin
							state_d = ffha_pkg::ST_DONE;
						end else if (free_idx_ext[IDX_W-1:0] == '0) begin
							rd_addr = '0;
							state_d = ffha_pkg::ST_F_T;
						end else begin
							rd_addr = '0;
							state_d = ffha_pkg::ST_F_WCHK;
						end
					end
				end
			end
			ffha_pkg::ST_A_RD: begin
				if (cur_q >= SIZE_W'(HEAP_WORDS)) begin
					res_addr_d = '0;
					res_code_d = ffha_pkg::OUT_OOM;
					state_d    = ffha_pkg::ST_DONE;
				end else begin
					rd_addr = cur_q[IDX_W-1:0];
					state_d = ffha_pkg::ST_A_CHK;
				end
			end
			ffha_pkg::ST_A_CHK: begin
				// One tag a cycle: stop at a fitting free block or the heap end.
				step_pos = cur_q + rd_size;
				if (rd_size == '0) begin
					res_addr_d = '0;
					res_code_d = ffha_pkg::OUT_OOM;
					state_d    = ffha_pkg::ST_DONE;
				end else if (rd_free && (CMP_W'(rd_size) >= CMP_W'(need_q))) begin
					t_d     = rd_data;
					state_d = ffha_pkg::ST_A_SPL;
				end else begin
					cur_d = step_pos;
					if (step_pos >= SIZE_W'(HEAP_WORDS)) begin
						res_addr_d = '0;
						res_code_d = ffha_pkg::OUT_OOM;
						state_d    = ffha_pkg::ST_DONE;
					end else begin
						rd_addr = step_pos[IDX_W-1:0];
					end
				end
			end
			ffha_pkg::ST_A_SPL: begin
				res_addr_d = byte_addr[AW-1:0];
				res_code_d = ffha_pkg::OUT_ALLOC;
				wr_en      = 1'b1;
				wr_addr    = cur_q[IDX_W-1:0];
				if (rem_w <= SIZE_W'(REM_MAX)) begin
					// Remainder too small for a header: hand out the whole block.
					wr_data = {t_size, t_prev, 1'b0};
					rover_d = (end_w < SIZE_W'(HEAP_WORDS)) ? end_w[IDX_W-1:0] : '0;
					state_d = ffha_pkg::ST_DONE;
				end else begin
					wr_data = {SIZE_W'(need_q), t_prev, 1'b0};
					nb_d    = nb_w[IDX_W-1:0];
					rem_d   = rem_w;
					rover_d = nb_w[IDX_W-1:0];
					if (end_w < SIZE_W'(HEAP_WORDS)) begin
						rd_addr = end_w[IDX_W-1:0];
						nn_d    = end_w[IDX_W-1:0];
						state_d = ffha_pkg::ST_A_NN;
					end else begin
						state_d = ffha_pkg::ST_A_NB;
					end
				end
			end
			ffha_pkg::ST_A_NN: begin
				wr_en   = 1'b1;
				wr_addr = nn_q;
				wr_data = {rd_size, nb_q, rd_free};
				state_d = ffha_pkg::ST_A_NB;
			end
			ffha_pkg::ST_A_NB: begin
				wr_en   = 1'b1;
				wr_addr = nb_q;
				wr_data = {rem_q, cur_q[IDX_W-1:0], 1'b1};
				state_d = ffha_pkg::ST_DONE;
			end
			ffha_pkg::ST_F_WCHK: begin
				// Walk the chain from the heap start to check the freed address.
				step_pos = cur_q + rd_size;
				cur_d    = step_pos;
				if (rd_size == '0) begin
					state_d = ffha_pkg::ST_DONE;
				end else if ((step_pos < SIZE_W'(HEAP_WORDS)) && (step_pos < SIZE_W'(idx_q))) begin
					rd_addr = step_pos[IDX_W-1:0];
				end else if (step_pos == SIZE_W'(idx_q)) begin
					rd_addr = idx_q;
					state_d = ffha_pkg::ST_F_T;
				end else begin
					state_d = ffha_pkg::ST_DONE;
				end
			end
			ffha_pkg::ST_F_T: begin
				t_d      = rd_data;
				step_pos = SIZE_W'(idx_q) + rd_size;
				nx_d     = step_pos;
				if (rd_free) begin
					state_d = ffha_pkg::ST_DONE;
				end else begin
					rd_addr = step_pos[IDX_W-1:0];
					state_d = ffha_pkg::ST_F_N;
				end
			end
			ffha_pkg::ST_F_N: begin
				nfree_d = (nx_q < SIZE_W'(HEAP_WORDS)) && rd_free;
				nsize_d = rd_size;
				rd_addr = t_prev;
				state_d = ffha_pkg::ST_F_P;
			end
			ffha_pkg::ST_F_P: begin
				// Merge with free neighbors and write the surviving head tag.
				wr_en = 1'b1;
				if ((idx_q != '0) && rd_free) begin
					head_w  = t_prev;
					hsize   = rd_size + size_i;
					wr_addr = t_prev;
					wr_data = {hsize, rd_prev, 1'b1};
				end else begin
					wr_addr = idx_q;
					wr_data = {size_i, t_prev, 1'b1};
				end
				after_w = SIZE_W'(head_w) + hsize;
				if (head_w < rover_q) begin
					rover_d = head_w;
				end
				if (after_w < SIZE_W'(HEAP_WORDS)) begin
					rd_addr = after_w[IDX_W-1:0];
					after_d = after_w[IDX_W-1:0];
					head_d  = head_w;
					state_d = ffha_pkg::ST_F_AF;
				end else begin
					state_d = ffha_pkg::ST_DONE;
				end
			end
			ffha_pkg::ST_F_AF: begin
				wr_en   = 1'b1;
				wr_addr = after_q;
				wr_data = {rd_size, head_q, rd_free};
				state_d = ffha_pkg::ST_DONE;
			end
			ffha_pkg::ST_DONE: begin
				if (out_free) begin
					out_valid_d = 1'b1;
					out_addr_d  = res_addr_q;
					out_code_d  = res_code_q;
					state_d     = ffha_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ffha_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffha_pkg::ST_INIT;
			rover_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rover_q     <= rover_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		out_addr_q <= out_addr_d;
		out_code_q <= out_code_d;
		cur_q      <= cur_d;
		need_q     <= need_d;
		idx_q      <= idx_d;
		t_q        <= t_d;
		nx_q       <= nx_d;
		nfree_q    <= nfree_d;
		nsize_q    <= nsize_d;
		head_q     <= head_d;
		after_q    <= after_d;
		nb_q       <= nb_d;
		rem_q      <= rem_d;
		nn_q       <= nn_d;
		res_addr_q <= res_addr_d;
		res_code_q <= res_code_d;
	end

`ifndef SYNTHESIS
	a_rover_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		SIZE_W'(rover_q) < SIZE_W'(HEAP_WORDS))
		else $error("rover outside the heap");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ffha_pkg::ST_IDLE))
		else $error("accepted request did not start work");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ffha_pkg::ST_DONE))
		else $error("result shown without finishing a request");

	a_check_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffha_pkg::ST_A_CHK) |->
		($past(state_q) == ffha_pkg::ST_A_RD || $past(state_q) == ffha_pkg::ST_A_CHK))
		else $error("tag checked without a read in flight");
`endif

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the first-fit heap allocator.
module tb_top;

	localparam int HEAP_WORDS = ffha_pkg::HEAP_BYTES / 4;
	localparam int HDR        = ffha_pkg::HEADER_BYTES;
	localparam int AW         = ffha_pkg::ADDR_W;
	localparam int IDLE_LIMIT = 200000;

	typedef struct packed {
		ffha_pkg::opcode_t        op;
		logic [AW-1:0]            req_bytes;
		logic [AW-1:0]            addr;
	} request_t;

	typedef struct packed {
		logic [AW-1:0]            uaddr;
		ffha_pkg::outcome_t       res;
	} answer_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 opcode;
	logic [AW-1:0]        request_bytes;
	logic [AW-1:0]        block_address;
	logic                 out_valid;
	logic                 out_stall;
	logic [AW-1:0]        user_address;
	logic [ffha_pkg::OUTCOME_W-1:0] outcome;

	first_fit_heap_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .request_bytes(request_bytes), .block_address(block_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.user_address(user_address), .outcome(outcome)
	);

	// Heap shadow: tag fields per word and the rover.
	int unsigned tag_size [HEAP_WORDS];
	int unsigned tag_prev [HEAP_WORDS];
	bit          tag_free [HEAP_WORDS];
	int unsigned rover;

	request_t    pending_reqs[$];
	answer_t     expected_answers[$];
	logic [AW-1:0] live_addrs[$];
	int          errors = 0;
	int          idle_cycles;
	bit          stim_done;
	bit          hold_sender;
	int          burst_left;
	int          gap_left;
	logic        in_acc;

	function automatic bit chain_has(int unsigned idx);
		int unsigned pos;
		pos = 0;
		while (pos < HEAP_WORDS && pos < idx) begin
			if (tag_size[pos] == 0)
				return 0;
			pos = pos + tag_size[pos];
		end
		return pos == idx && pos < HEAP_WORDS;
	endfunction

	function automatic answer_t heap_allocate(int unsigned req);
		answer_t a;
		int unsigned need, cur, rem, nb, nn;
		bit found;
		need = ((req + HDR + 3) & ~32'd3) >> 2;
		cur = rover;
		found = 0;
		while (cur < HEAP_WORDS) begin
			if (tag_size[cur] == 0)
				break;
			if (tag_free[cur] && tag_size[cur] >= need) begin
				found = 1;
				break;
			end
			cur = cur + tag_size[cur];
		end
		if (!found) begin
			a.uaddr = '0;
			a.res = ffha_pkg::OUT_OOM;
			return a;
		end
		rem = tag_size[cur] - need;
		tag_free[cur] = 0;
		if (rem * 4 <= HDR) begin
			nn = cur + tag_size[cur];
			rover = (nn < HEAP_WORDS) ? nn : 0;
		end else begin
			nb = cur + need;
			tag_size[cur] = need;
			tag_size[nb] = rem;
			tag_prev[nb] = cur;
			tag_free[nb] = 1;
			rover = nb;
			nn = nb + rem;
			if (nn < HEAP_WORDS)
				tag_prev[nn] = nb;
		end
		a.uaddr = AW'(cur * 4 + HDR);
		a.res = ffha_pkg::OUT_ALLOC;
		return a;
	endfunction

	function automatic answer_t heap_release(int unsigned addr);
		answer_t a;
		int unsigned idx, head, nx, pv, after;
		a.uaddr = '0;
		a.res = ffha_pkg::OUT_FREED;
		if (addr < HDR || ((addr - HDR) & 3) != 0)
			return a;
		idx = (addr - HDR) >> 2;
		if (idx >= HEAP_WORDS || !chain_has(idx) || tag_free[idx])
			return a;
		head = idx;
		nx = idx + tag_size[idx];
		tag_free[idx] = 1;
		if (nx < HEAP_WORDS && tag_free[nx])
			tag_size[idx] += tag_size[nx];
		if (idx != 0) begin
			pv = tag_prev[idx];
			if (pv < HEAP_WORDS && tag_free[pv]) begin
				tag_size[pv] += tag_size[idx];
				head = pv;
			end
		end
		after = head + tag_size[head];
		if (after < HEAP_WORDS)
			tag_prev[after] = head;
		if (head < rover)
			rover = head;
		return a;
	endfunction

	task automatic push_req(ffha_pkg::opcode_t op, int unsigned nbytes, int unsigned addr);
		request_t r;
		r.op = op;
		r.req_bytes = AW'(nbytes);
		r.addr = AW'(addr);
		pending_reqs.push_back(r);
	endtask

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stimulus: directed corners, then alloc/free mixes driven by live addresses.
	initial begin
		int sel, k;
		arst_n = 1'b0;
		stim_done = 0;
		hold_sender = 0;
		for (int i = 0; i < HEAP_WORDS; i++) begin
			tag_size[i] = 0;
			tag_prev[i] = 0;
			tag_free[i] = 0;
		end
		tag_size[0] = HEAP_WORDS;
		tag_free[0] = 1;
		rover = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Sole block freed, invalid frees, zero and maximum sizes.
		push_req(ffha_pkg::OP_ALLOC, 0, 0);
		push_req(ffha_pkg::OP_FREE, 0, 12);
		push_req(ffha_pkg::OP_FREE, 0, 12);
		push_req(ffha_pkg::OP_FREE, 0, 0);
		push_req(ffha_pkg::OP_FREE, 0, 13);
		push_req(ffha_pkg::OP_FREE, 0, 16'hFFFF);
		push_req(ffha_pkg::OP_ALLOC, 16'hFFFF, 0);
		push_req(ffha_pkg::OP_ALLOC, 65524, 16'hFFFF);
		push_req(ffha_pkg::OP_FREE, 16'hFFFF, 12);
		push_req(ffha_pkg::OP_ALLOC, 65521, 0);
		push_req(ffha_pkg::OP_ALLOC, 100, 0);
		push_req(ffha_pkg::OP_ALLOC, 8, 0);
		push_req(ffha_pkg::OP_ALLOC, 5, 0);
		push_req(ffha_pkg::OP_FREE, 0, 136);
		push_req(ffha_pkg::OP_FREE, 0, 12);
		push_req(ffha_pkg::OP_FREE, 0, 124);
		push_req(ffha_pkg::OP_FREE, 0, 20);
		push_req(ffha_pkg::OP_ALLOC, 40000, 0);
		push_req(ffha_pkg::OP_ALLOC, 30000, 0);
		push_req(ffha_pkg::OP_ALLOC, 25000, 0);
		push_req(ffha_pkg::OP_FREE, 0, 12);

		wait (pending_reqs.size() == 0 && expected_answers.size() == 0);
		hold_sender = 1;
		repeat (40) @(posedge clk);
		hold_sender = 0;

		for (int n = 0; n < 1600; n++) begin
			wait (pending_reqs.size() < 4);
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				k = $urandom_range(0, 9);
				push_req(ffha_pkg::OP_ALLOC, k == 0 ? $urandom_range(0, 65535) :
					(k < 3 ? $urandom_range(0, 4096) : $urandom_range(0, 300)),
					$urandom_range(0, 65535));
			end else if (sel < 88 && live_addrs.size() > 0) begin
				k = $urandom_range(0, live_addrs.size() - 1);
				push_req(ffha_pkg::OP_FREE, $urandom_range(0, 65535), live_addrs[k]);
				live_addrs.delete(k);
			end else begin
				push_req(ffha_pkg::OP_FREE, $urandom_range(0, 65535),
					$urandom_range(0, 65535));
			end
			if (n == 800) begin
				wait (pending_reqs.size() == 0 && expected_answers.size() == 0);
				hold_sender = 1;
				repeat (20) @(posedge clk);
				hold_sender = 0;
			end
		end
		wait (pending_reqs.size() == 0);
		stim_done = 1;
	end

	// Driver: bursts and gaps; a request is held until it is accepted.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			opcode <= 1'b0;
			request_bytes <= '0;
			block_address <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_acc) begin
			if (gap_left > 0 || hold_sender || pending_reqs.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				in_valid <= 1'b1;
				opcode <= pending_reqs[0].op;
				request_bytes <= pending_reqs[0].req_bytes;
				block_address <= pending_reqs[0].addr;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Receiver stall pattern: quiet stretches and stall-heavy stretches.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else if ((($urandom_range(0, 3)) & (idle_cycles >> 7)) == 0 && $urandom_range(0, 255) < 220)
			out_stall <= ($urandom_range(0, 3) == 0);
		else
			out_stall <= ($urandom_range(0, 1) == 0);
	end

	// Monitor: predict on accepted requests, compare on accepted results.
	always @(posedge clk) begin
		request_t r;
		answer_t a;
		answer_t exp_a;
		in_acc <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				r = pending_reqs.pop_front();
				if (r.op == ffha_pkg::OP_ALLOC)
					a = heap_allocate(r.req_bytes);
				else
					a = heap_release(r.addr);
				if (r.op == ffha_pkg::OP_ALLOC && a.res == ffha_pkg::OUT_ALLOC)
					live_addrs.push_back(a.uaddr);
				expected_answers.push_back(a);
			end
			if (out_valid && !out_stall) begin
				if (expected_answers.size() == 0) begin
					$error("result with no request pending: user_address %0d outcome %0d",
						user_address, outcome);
					errors++;
				end else begin
					exp_a = expected_answers.pop_front();
					if (user_address !== exp_a.uaddr) begin
						$error("user_address expected %0d actual %0d", exp_a.uaddr, user_address);
						errors++;
					end
					if (outcome !== exp_a.res) begin
						$error("outcome expected %0d actual %0d", exp_a.res, outcome);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog on cycles without any handshake.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		bit timed_out;
		timed_out = 0;
		fork
			begin
				wait (stim_done && expected_answers.size() == 0);
				repeat (100) @(posedge clk);
			end
			begin
				wait (idle_cycles >= IDLE_LIMIT);
				timed_out = 1;
			end
		join_any
		if (errors == 0 && !timed_out && expected_answers.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: filelist.f
src/ffha_pkg.sv
src/ffha_ram.sv
src/first_fit_heap_allocator.sv
dv/tb_top.sv
